/* sv/dmrc_pkg.sv */
// Shared types, constants and ramp helper functions for the dual motor ramp controller.
package dmrc_pkg;

    localparam int SPEED_W     = 9;
    localparam int DUTY_W      = 8;
    localparam int STEP_W      = 8;
    localparam int HOLD_W      = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_STEP      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_HOLD_TICKS = 4'd1;

    localparam logic [STEP_W-1:0] SPEED_STEP_RESET      = 8'd1;
    localparam logic [HOLD_W-1:0] STOP_HOLD_TICKS_RESET = 16'd100;

    typedef logic signed [SPEED_W-1:0] speed_t;

    typedef enum logic [1:0] {
        MODE_STOPPED      = 2'd0,
        MODE_ACCELERATING = 2'd1,
        MODE_MOVING       = 2'd2,
        MODE_STOPPING     = 2'd3
    } mode_t;

    // -256 folds to -255 so the magnitude always fits the duty field
    function automatic speed_t sat_target(input speed_t raw);
        speed_t res;
        res = raw;
        if (raw == 9'sh100)
        begin
            res = -9'sd255;
        end
        return res;
    endfunction

    // One ramp step toward goal, clamped at the goal
    function automatic speed_t step_toward(input speed_t cur, input speed_t goal,
                                           input logic [STEP_W-1:0] step);
        logic signed [10:0] diff;
        logic signed [10:0] st;
        logic signed [10:0] sum;
        speed_t             res;
        diff = 11'(goal) - 11'(cur);
        st   = signed'({3'b000, step});
        res  = goal;
        if (diff > st)
        begin
            sum = 11'(cur) + st;
            res = sum[SPEED_W-1:0];
        end
        else if (diff < -st)
        begin
            sum = 11'(cur) - st;
            res = sum[SPEED_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input speed_t s);
        speed_t mag;
        mag = s[SPEED_W-1] ? -s : s;
        return mag[DUTY_W-1:0];
    endfunction

endpackage

/* sv/dmrc_target_if.sv */
// Request channel carrying the left and right target speeds of one tick.
interface dmrc_target_if;
    logic                          valid;
    logic                          ready;
    logic signed [dmrc_pkg::SPEED_W-1:0] target_left;
    logic signed [dmrc_pkg::SPEED_W-1:0] target_right;

    modport source (output valid, output target_left, output target_right, input ready);
    modport sink   (input valid, input target_left, input target_right, output ready);
endinterface

/* sv/dmrc_result_if.sv */
// Result channel carrying bridge direction, duty and mode for one tick.
interface dmrc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         left_reverse;
    logic [dmrc_pkg::DUTY_W-1:0]  left_duty;
    logic                         right_reverse;
    logic [dmrc_pkg::DUTY_W-1:0]  right_duty;
    logic [1:0]                   motion_mode;

    modport source (output valid, output left_reverse, output left_duty,
                    output right_reverse, output right_duty, output motion_mode,
                    input ready);
    modport sink   (input valid, input left_reverse, input left_duty,
                    input right_reverse, input right_duty, input motion_mode,
                    output ready);
endinterface

/* sv/dmrc_cfg_if.sv */
// Configuration write channel: register index and write data.
interface dmrc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dmrc_pkg::CFG_INDEX_W-1:0]   index;
    logic [dmrc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/dual_motor_ramp_controller.sv */
// Top level of the dual motor speed ramp controller.
//
// Usage notes
// - target: one request per control tick with signed left/right target speeds
//   (-256 is treated as -255). Each accepted request yields exactly one result.
// - result: reverse flag and 8-bit duty per H-bridge, plus the motion mode
//   (0 stopped, 1 accelerating, 2 moving, 3 stopping) after the tick's update.
// - cfg: register writes (0 speed_step, 1 stop_hold_ticks), always ready;
//   unknown indexes are dropped, data is truncated to the register width.
// - Latency: the result is presented the cycle after its request is taken.
// - Throughput: one request per cycle while no held result is stalled by the
//   receiver; the whole tick update is a single compare/add pass into the
//   result register, so the result register is the only stage that sets the rate.
// - If the receiver stalls, the result holds and target.ready stays high only
//   when the held result is being taken in the same cycle.
// - Reset: mode stopped, speeds zero, hold count zero, speed_step 1,
//   stop_hold_ticks 100, no result pending.
module dual_motor_ramp_controller
(
    input  logic                  clk,
    input  logic                  rst_n,
    dmrc_target_if.sink           target,
    dmrc_result_if.source         result,
    dmrc_cfg_if.sink              cfg
);

    // Configuration registers
    logic [dmrc_pkg::STEP_W-1:0] speed_step_reg;
    logic [dmrc_pkg::HOLD_W-1:0] stop_hold_ticks_reg;

    // Tick state
    dmrc_pkg::mode_t             mode_reg, mode_next;
    dmrc_pkg::speed_t            speed_left_reg, speed_left_next;
    dmrc_pkg::speed_t            speed_right_reg, speed_right_next;
    logic [dmrc_pkg::HOLD_W-1:0] hold_count_reg, hold_count_next;

    // Result register
    logic                        out_valid_reg;
    logic                        left_reverse_reg;
    logic [dmrc_pkg::DUTY_W-1:0] left_duty_reg;
    logic                        right_reverse_reg;
    logic [dmrc_pkg::DUTY_W-1:0] right_duty_reg;
    logic [1:0]                  motion_mode_reg;

    dmrc_pkg::speed_t            tl;
    dmrc_pkg::speed_t            tr;
    logic                        take;

    // Accept while the result slot is empty or draining this cycle
    assign target.ready = !out_valid_reg || result.ready;
    assign take         = target.valid && target.ready;
    assign cfg.ready    = 1'b1;

    assign tl = dmrc_pkg::sat_target(target.target_left);
    assign tr = dmrc_pkg::sat_target(target.target_right);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_step_reg      <= dmrc_pkg::SPEED_STEP_RESET;
            stop_hold_ticks_reg <= dmrc_pkg::STOP_HOLD_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dmrc_pkg::REG_SPEED_STEP:
                begin
                    speed_step_reg <= cfg.data[dmrc_pkg::STEP_W-1:0];
                end
                dmrc_pkg::REG_STOP_HOLD_TICKS:
                begin
                    stop_hold_ticks_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Next state for one tick
    always_comb
    begin
        mode_next        = mode_reg;
        speed_left_next  = speed_left_reg;
        speed_right_next = speed_right_reg;
        hold_count_next  = hold_count_reg;
        case (mode_reg)
            dmrc_pkg::MODE_MOVING:
            begin
                // any change of target forces a full stop first
                if (speed_left_reg != tl || speed_right_reg != tr)
                begin
                    mode_next = dmrc_pkg::MODE_STOPPING;
                end
            end
            dmrc_pkg::MODE_STOPPING:
            begin
                speed_left_next  = dmrc_pkg::step_toward(speed_left_reg, '0, speed_step_reg);
                speed_right_next = dmrc_pkg::step_toward(speed_right_reg, '0, speed_step_reg);
                if (speed_left_next == '0 && speed_right_next == '0)
                begin
                    mode_next       = dmrc_pkg::MODE_STOPPED;
                    hold_count_next = stop_hold_ticks_reg;
                end
            end
            dmrc_pkg::MODE_STOPPED:
            begin
                // hold at standstill, then start ramping
                if (speed_left_reg != tl || speed_right_reg != tr)
                begin
                    if (hold_count_reg != '0)
                    begin
                        hold_count_next = hold_count_reg - dmrc_pkg::HOLD_W'(1);
                    end
                    else
                    begin
                        mode_next = dmrc_pkg::MODE_ACCELERATING;
                    end
                end
            end
            default:
            begin
                // accelerating: head straight for the current targets
                speed_left_next  = dmrc_pkg::step_toward(speed_left_reg, tl, speed_step_reg);
                speed_right_next = dmrc_pkg::step_toward(speed_right_reg, tr, speed_step_reg);
                if (speed_left_next == tl && speed_right_next == tr)
                begin
                    mode_next = dmrc_pkg::MODE_MOVING;
                end
            end
        endcase
    end

    // State register, advances once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= dmrc_pkg::MODE_STOPPED;
            speed_left_reg  <= '0;
            speed_right_reg <= '0;
            hold_count_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg        <= mode_next;
            speed_left_reg  <= speed_left_next;
            speed_right_reg <= speed_right_next;
            hold_count_reg  <= hold_count_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_reverse_reg  <= speed_left_next[dmrc_pkg::SPEED_W-1];
            left_duty_reg     <= dmrc_pkg::duty_of(speed_left_next);
            right_reverse_reg <= speed_right_next[dmrc_pkg::SPEED_W-1];
            right_duty_reg    <= dmrc_pkg::duty_of(speed_right_next);
            motion_mode_reg   <= mode_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.left_reverse  = left_reverse_reg;
    assign result.left_duty     = left_duty_reg;
    assign result.right_reverse = right_reverse_reg;
    assign result.right_duty    = right_duty_reg;
    assign result.motion_mode   = motion_mode_reg;

endmodule

/* tb/ramp_check_pkg.sv */
// Scoreboard class: tick predictor and queue of expected bridge outputs.
`timescale 1ns / 1ps
package ramp_check_pkg;

    import dmrc_pkg::*;

    typedef struct {
        logic              left_reverse;
        logic [DUTY_W-1:0] left_duty;
        logic              right_reverse;
        logic [DUTY_W-1:0] right_duty;
        mode_t             motion_mode;
    } bridge_out_t;

    class ramp_scoreboard;

        mode_t       mode;
        int          speed_left;
        int          speed_right;
        int          hold_left;
        int          ramp_step;
        int          hold_ticks;
        int          errors;
        bridge_out_t due_outputs[$];

        function new();
            mode        = MODE_STOPPED;
            speed_left  = 0;
            speed_right = 0;
            hold_left   = 0;
            ramp_step   = int'(SPEED_STEP_RESET);
            hold_ticks  = int'(STOP_HOLD_TICKS_RESET);
            errors      = 0;
        endfunction

        function void load_register(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
            if (idx == REG_SPEED_STEP)
            begin
                ramp_step = int'(val[STEP_W-1:0]);
            end
            else if (idx == REG_STOP_HOLD_TICKS)
            begin
                hold_ticks = int'(val[HOLD_W-1:0]);
            end
        endfunction

        // clamped move of cur toward goal by at most st
        function int ramp_toward(input int cur, input int goal, input int st);
            if (cur < goal)
            begin
                return (goal - cur > st) ? cur + st : goal;
            end
            if (cur > goal)
            begin
                return (cur - goal > st) ? cur - st : goal;
            end
            return cur;
        endfunction

        // advance one tick and queue the outputs it produces
        function void note_request(input speed_t raw_left, input speed_t raw_right);
            int          goal_left;
            int          goal_right;
            int          mag;
            bridge_out_t out;
            goal_left  = int'(raw_left);
            goal_right = int'(raw_right);
            if (goal_left < -255)
            begin
                goal_left = -255;
            end
            if (goal_right < -255)
            begin
                goal_right = -255;
            end
            case (mode)
                MODE_MOVING:
                begin
                    if (speed_left != goal_left || speed_right != goal_right)
                    begin
                        mode = MODE_STOPPING;
                    end
                end
                MODE_STOPPING:
                begin
                    speed_left  = ramp_toward(speed_left, 0, ramp_step);
                    speed_right = ramp_toward(speed_right, 0, ramp_step);
                    if (speed_left == 0 && speed_right == 0)
                    begin
                        mode      = MODE_STOPPED;
                        hold_left = hold_ticks;
                    end
                end
                MODE_STOPPED:
                begin
                    if (speed_left != goal_left || speed_right != goal_right)
                    begin
                        if (hold_left > 0)
                        begin
                            hold_left = hold_left - 1;
                        end
                        else
                        begin
                            mode = MODE_ACCELERATING;
                        end
                    end
                end
                default:
                begin
                    speed_left  = ramp_toward(speed_left, goal_left, ramp_step);
                    speed_right = ramp_toward(speed_right, goal_right, ramp_step);
                    if (speed_left == goal_left && speed_right == goal_right)
                    begin
                        mode = MODE_MOVING;
                    end
                end
            endcase
            out.left_reverse  = (speed_left < 0);
            mag               = (speed_left < 0) ? -speed_left : speed_left;
            out.left_duty     = mag[DUTY_W-1:0];
            out.right_reverse = (speed_right < 0);
            mag               = (speed_right < 0) ? -speed_right : speed_right;
            out.right_duty    = mag[DUTY_W-1:0];
            out.motion_mode   = mode;
            due_outputs.push_back(out);
        endfunction

        function void check_result(input logic lrev, input logic [DUTY_W-1:0] lduty,
                                   input logic rrev, input logic [DUTY_W-1:0] rduty,
                                   input logic [1:0] mmode);
            bridge_out_t want;
            if (due_outputs.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = due_outputs.pop_front();
            if (lrev !== want.left_reverse)
            begin
                $error("left_reverse: expected %0d, actual %0d", want.left_reverse, lrev);
                errors++;
            end
            if (lduty !== want.left_duty)
            begin
                $error("left_duty: expected %0d, actual %0d", want.left_duty, lduty);
                errors++;
            end
            if (rrev !== want.right_reverse)
            begin
                $error("right_reverse: expected %0d, actual %0d", want.right_reverse, rrev);
                errors++;
            end
            if (rduty !== want.right_duty)
            begin
                $error("right_duty: expected %0d, actual %0d", want.right_duty, rduty);
                errors++;
            end
            if (mmode !== want.motion_mode)
            begin
                $error("motion_mode: expected %0d, actual %0d", want.motion_mode, mmode);
                errors++;
            end
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction

    endclass

endpackage

/* tb/testbench.sv */
// Top-level testbench for the dual motor ramp controller: stimulus, idling and checks.
`timescale 1ns / 1ps
module testbench;

    import dmrc_pkg::*;
    import ramp_check_pkg::*;

    // cycles with no handshake on any channel before the run is declared hung;
    // the longest legitimate quiet spell is the forced receiver hold-off plus a gap
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 400;
    localparam int TAIL_CYCLES    = 8;

    // indexes past the register list, which the block must drop
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = REG_STOP_HOLD_TICKS + CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    logic clk;
    logic rst_n;

    dmrc_target_if tgt ();
    dmrc_result_if res ();
    dmrc_cfg_if    cfg_bus ();

    ramp_scoreboard sb;

    // set by the stimulus: no_idle removes all gaps on both sides,
    // long_stall_req asks the receiver for one long hold-off
    bit no_idle;
    bit long_stall_req;

    dual_motor_ramp_controller DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .target (tgt),
        .result (res),
        .cfg    (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // small speeds so slow ramps finish, full raw range (incl. -256), and extremes
    function automatic speed_t pick_target();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            v = int'($urandom_range(0, 40)) - 20;
            return speed_t'(v);
        end
        if (r < 7)
        begin
            return speed_t'($urandom_range(0, 511));
        end
        if (r == 7)
        begin
            return 9'sd255;
        end
        if (r == 8)
        begin
            return -9'sd255;
        end
        return 9'sh100;
    endfunction

    // Offer one tick request, wait for it to be taken, then optionally leave a gap.
    // With no gap valid simply stays high into the next request.
    task automatic send_tick(input speed_t tl, input speed_t tr);
        int gap;
        @(negedge clk);
        tgt.valid        <= 1'b1;
        tgt.target_left  <= tl;
        tgt.target_right <= tr;
        @(posedge clk);
        while (!tgt.ready)
        begin
            @(posedge clk);
        end
        sb.note_request(tl, tr);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            tgt.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_ticks(input speed_t tl, input speed_t tr, input int count);
        repeat (count) send_tick(tl, tr);
    endtask

    // Sender goes quiet until every outstanding result has come back
    task automatic drain();
        @(negedge clk);
        tgt.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        sb.load_register(idx, val);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random traffic for one configuration. Mostly held targets that run until
    // the motors settle at speed (plus a few extra ticks), the rest per-tick
    // noise and targets abandoned part way through a ramp.
    task automatic run_traffic(input int quota);
        int     sent;
        int     kind;
        int     n;
        int     extra;
        int     cut;
        speed_t tl;
        speed_t tr;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(0, 99);
            tl   = pick_target();
            tr   = pick_target();
            if (kind < 65)
            begin
                n     = 0;
                extra = $urandom_range(0, 4);
                while (n < 60 && sent < quota)
                begin
                    send_tick(tl, tr);
                    n++;
                    sent++;
                    if (sb.mode == MODE_MOVING)
                    begin
                        if (extra == 0)
                        begin
                            break;
                        end
                        extra--;
                    end
                end
            end
            else if (kind < 85)
            begin
                n = $urandom_range(1, 6);
                while (n > 0 && sent < quota)
                begin
                    send_tick(pick_target(), pick_target());
                    n--;
                    sent++;
                end
            end
            else
            begin
                cut = $urandom_range(1, 8);
                while (cut > 0 && sent < quota)
                begin
                    send_tick(tl, tr);
                    cut--;
                    sent++;
                end
            end
        end
    endtask

    // Result side: ready drops in random gaps, or for one long hold-off on request,
    // or never while no_idle is set.
    initial
    begin : result_sink
        int stall_left;
        int g;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left     = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                res.ready <= 1'b0;
                stall_left--;
            end
            else if (no_idle)
            begin
                res.ready <= 1'b1;
            end
            else
            begin
                g = pick_gap();
                if (g == 0)
                begin
                    res.ready <= 1'b1;
                end
                else
                begin
                    res.ready <= 1'b0;
                    stall_left = g - 1;
                end
            end
        end
    end

    // Results are sampled at the rising edge, before the block's own updates land
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            sb.check_result(res.left_reverse, res.left_duty, res.right_reverse,
                            res.right_duty, res.motion_mode);
        end
    end

    // Hang detector: any handshake on any channel resets the count
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tgt.valid && tgt.ready) || (res.valid && res.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int quota;
        logic [CFG_DATA_W-1:0] step_val;
        logic [CFG_DATA_W-1:0] hold_val;

        // every input known from time zero
        sb                   = new();
        no_idle              = 1'b0;
        long_stall_req       = 1'b0;
        rst_n                = 1'b0;
        tgt.valid            = 1'b0;
        tgt.target_left      = '0;
        tgt.target_right     = '0;
        res.ready            = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_SPEED_STEP;
        cfg_bus.data         = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // full step so ramps complete in one tick, short standstill
        write_reg(REG_SPEED_STEP, CFG_DATA_W'(STEP_MAX));
        write_reg(REG_STOP_HOLD_TICKS, 16'd2);

        // at target already: stays stopped
        send_ticks(9'sd0, 9'sd0, 2);
        // first target after reset: hold count is zero so it accelerates at once;
        // -256 on the right saturates to -255, large step clamps at the target
        send_ticks(9'sd255, 9'sh100, 3);
        // reversal from moving: stop, clamp to zero, two-tick hold, accelerate
        send_ticks(-9'sd255, 9'sd255, 6);

        drain();
        write_reg(REG_SPEED_STEP, 16'd100);
        write_reg(REG_STOP_HOLD_TICKS, 16'd0);
        // ramp down in steps of 100, no hold, start accelerating
        send_ticks(9'sd250, -9'sd250, 5);
        // target change while accelerating: heads straight for the new target
        send_ticks(-9'sd200, 9'sd90, 4);
        // both at the negative extreme
        send_ticks(9'sh100, 9'sh100, 3);

        // ---- random part, one configuration per phase ----
        for (p = 0; p < 12; p++)
        begin
            // a pause until every result is home, then reconfigure while idle
            drain();
            quota   = 155;
            no_idle = (p == 1 || p == 7);
            case (p)
                0:
                begin
                    step_val = CFG_DATA_W'(SPEED_STEP_RESET);
                    hold_val = CFG_DATA_W'(STOP_HOLD_TICKS_RESET);
                end
                1:
                begin
                    step_val = CFG_DATA_W'(STEP_MAX);
                    hold_val = '0;
                end
                2:
                begin
                    // zero step freezes the ramps; kept short
                    step_val = '0;
                    hold_val = 16'd5;
                    quota    = 40;
                end
                3:
                begin
                    // upper bits must be dropped: step becomes 5
                    step_val = 16'hAB05;
                    hold_val = '0;
                end
                5:
                begin
                    step_val = 16'd2;
                    hold_val = 16'd1;
                end
                6:
                begin
                    step_val = CFG_DATA_W'($urandom_range(1, 32));
                    hold_val = CFG_DATA_W'($urandom_range(0, 20));
                end
                7:
                begin
                    step_val = CFG_DATA_W'(STEP_MAX);
                    hold_val = 16'd3;
                end
                11:
                begin
                    step_val = CFG_DATA_W'($urandom_range(1, 255));
                    hold_val = CFG_DATA_W'(HOLD_MAX);
                end
                default:
                begin
                    step_val = CFG_DATA_W'($urandom_range(1, 255));
                    hold_val = CFG_DATA_W'($urandom_range(0, 10));
                end
            endcase
            write_reg(REG_SPEED_STEP, step_val);
            write_reg(REG_STOP_HOLD_TICKS, hold_val);
            if (p == 3 || p == 8)
            begin
                // writes to indexes past the list must not disturb anything
                write_reg(CFG_INDEX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_UNUSED_HI, '1);
            end
            if (p == 5)
            begin
                // receiver holds off while requests keep coming, filling the block
                long_stall_req = 1'b1;
            end
            run_traffic(quota);
        end

        // ---- wind-down ----
        drain();
        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
